// ----- src/bcomp_pkg.sv -----
package bcomp_pkg;

    // Field and port widths
    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int TEMP_W = 19;
    localparam int PRES_W = 20;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Internal datapath widths
    localparam int DT_W   = 25;   // dT = D2 - C5 * 2^8
    localparam int TW_W   = 20;   // working temperature before saturation
    localparam int OS_W   = 40;   // offset, sensitivity and correction terms
    localparam int MA_W   = 40;   // multiplicand of the serial multiplier
    localparam int DIG_W  = 4;    // multiplier digit retired per cycle
    localparam int NDIG   = 7;    // digits per multiplier operand
    localparam int MB_W   = NDIG * DIG_W;
    localparam int PROD_W = 64;
    localparam int PX_W   = 44;   // (D1 * SENS >> 21) - OFF
    localparam int PQ_W   = 29;   // pressure before saturation

    // Formula constants
    localparam int TEMP_REF = 2000;
    localparam int TEMP_LOW = -1500;
    localparam int TEMP_MIN = -140000;
    localparam int TEMP_MAX = 140000;
    localparam int PRES_MAX = 1048575;

    localparam int SH_C5    = 8;
    localparam int SH_C2    = 16;
    localparam int SH_C1    = 15;
    localparam int SH_TEMP  = 23;
    localparam int SH_OFF   = 7;
    localparam int SH_SENS  = 8;
    localparam int SH_T2    = 31;
    localparam int SH_OFF2  = 1;
    localparam int SH_SENS2 = 2;
    localparam int SH_SENS3 = 1;
    localparam int SH_P1    = 21;
    localparam int SH_P2    = 15;

    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } cal_t;

    typedef struct packed {
        logic                     start;
        logic signed [MA_W-1:0]   a;
        logic signed [MB_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } mul_rsp_t;

endpackage

// ----- src/bcomp_if.sv -----
interface bcomp_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [bcomp_pkg::RAW_W-1:0]      raw_sample;

    modport source (output valid, output action, output raw_sample, input ready);
    modport sink   (input valid, input action, input raw_sample, output ready);
endinterface

interface bcomp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [bcomp_pkg::TEMP_W-1:0] temperature_centi;
    logic [bcomp_pkg::PRES_W-1:0]     pressure_pa;
    logic                             pressure_valid;

    modport source (output valid, output temperature_centi, output pressure_pa,
                    output pressure_valid, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pa,
                    input pressure_valid, output ready);
endinterface

// ----- src/bcomp_regs.sv -----
module bcomp_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcomp_pkg::ADDR_W-1:0]   paddr,
    input  logic [bcomp_pkg::DATA_W-1:0]   pwdata,
    output logic [bcomp_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    output bcomp_pkg::cal_t                cal
);

    bcomp_pkg::cal_t     cal_reg;
    bcomp_pkg::cal_t     cal_next;
    bcomp_pkg::reg_idx_t idx;
    logic                wr_en;
    logic [bcomp_pkg::CAL_W-1:0] wdata;

    assign idx    = bcomp_pkg::reg_idx_t'(paddr[bcomp_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign wdata  = pwdata[bcomp_pkg::CAL_W-1:0];
    assign pready = 1'b1;
    assign cal    = cal_reg;

    always_comb
    begin
        cal_next = cal_reg;
        prdata   = '0;
        unique case (idx)
            bcomp_pkg::REG_C1:
            begin
                prdata = bcomp_pkg::DATA_W'(cal_reg.c1);
                if (wr_en)
                begin
                    cal_next.c1 = wdata;
                end
            end
            bcomp_pkg::REG_C2:
            begin
                prdata = bcomp_pkg::DATA_W'(cal_reg.c2);
                if (wr_en)
                begin
                    cal_next.c2 = wdata;
                end
            end
            bcomp_pkg::REG_C3:
            begin
                prdata = bcomp_pkg::DATA_W'(cal_reg.c3);
                if (wr_en)
                begin
                    cal_next.c3 = wdata;
                end
            end
            bcomp_pkg::REG_C4:
            begin
                prdata = bcomp_pkg::DATA_W'(cal_reg.c4);
                if (wr_en)
                begin
                    cal_next.c4 = wdata;
                end
            end
            bcomp_pkg::REG_C5:
            begin
                prdata = bcomp_pkg::DATA_W'(cal_reg.c5);
                if (wr_en)
                begin
                    cal_next.c5 = wdata;
                end
            end
            bcomp_pkg::REG_C6:
            begin
                prdata = bcomp_pkg::DATA_W'(cal_reg.c6);
                if (wr_en)
                begin
                    cal_next.c6 = wdata;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

endmodule

// ----- src/bcomp_smul.sv -----
module bcomp_smul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bcomp_pkg::mul_req_t  req,
    output bcomp_pkg::mul_rsp_t  rsp
);

    localparam int CNT_W  = $clog2(bcomp_pkg::NDIG);
    localparam int HI_W   = bcomp_pkg::MA_W + bcomp_pkg::DIG_W;
    localparam int PP_W   = bcomp_pkg::MA_W + bcomp_pkg::DIG_W + 1;
    localparam int SUM_W  = HI_W + 2;
    localparam int FULL_W = HI_W + bcomp_pkg::MB_W;

    logic signed [bcomp_pkg::MA_W-1:0] a_reg;
    logic signed [bcomp_pkg::MA_W-1:0] a_next;
    logic signed [HI_W-1:0]            hi_reg;
    logic signed [HI_W-1:0]            hi_next;
    logic [bcomp_pkg::MB_W-1:0]        lo_reg;
    logic [bcomp_pkg::MB_W-1:0]        lo_next;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;

    logic                              last;
    logic signed [bcomp_pkg::DIG_W:0]  dig;
    logic signed [PP_W-1:0]            pp;
    logic signed [SUM_W-1:0]           sum;
    logic [FULL_W-1:0]                 full;

    // The lowest unretired digit of the multiplier; the top digit carries the sign.
    assign last = (cnt_reg == CNT_W'(bcomp_pkg::NDIG - 1));
    assign dig  = $signed({last & lo_reg[bcomp_pkg::DIG_W-1], lo_reg[bcomp_pkg::DIG_W-1:0]});
    assign pp   = a_reg * dig;
    assign sum  = SUM_W'(hi_reg) + SUM_W'(pp);

    always_comb
    begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            hi_next   = '0;
            lo_next   = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Retired product bits drop into the low register as the multiplier shifts out.
            hi_next  = HI_W'(sum >>> bcomp_pkg::DIG_W);
            lo_next  = {sum[bcomp_pkg::DIG_W-1:0], lo_reg[bcomp_pkg::MB_W-1:bcomp_pkg::DIG_W]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign full     = {hi_reg, lo_reg};
    assign rsp.done = done_reg;
    assign rsp.prod = full[bcomp_pkg::PROD_W-1:0];

endmodule

// ----- src/bcomp_core.sv -----
module bcomp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  bcomp_pkg::cal_t   cal,
    bcomp_in_if.sink          din,
    bcomp_out_if.source       dout
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_M_TEMP   = 13'b0000000000010,
        S_M_OFF    = 13'b0000000000100,
        S_M_SENS   = 13'b0000000001000,
        S_M_F      = 13'b0000000010000,
        S_F_APPLY  = 13'b0000000100000,
        S_M_F2     = 13'b0000001000000,
        S_F2_APPLY = 13'b0000010000000,
        S_M_T2     = 13'b0000100000000,
        S_FINAL    = 13'b0001000000000,
        S_M_PRES   = 13'b0010000000000,
        S_P_CALC   = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [bcomp_pkg::DT_W-1:0]   dt_reg;
    logic signed [bcomp_pkg::DT_W-1:0]   dt_next;
    logic signed [bcomp_pkg::TW_W-1:0]   temp_reg;
    logic signed [bcomp_pkg::TW_W-1:0]   temp_next;
    logic signed [bcomp_pkg::OS_W-1:0]   off_reg;
    logic signed [bcomp_pkg::OS_W-1:0]   off_next;
    logic signed [bcomp_pkg::OS_W-1:0]   sens_reg;
    logic signed [bcomp_pkg::OS_W-1:0]   sens_next;
    logic signed [bcomp_pkg::OS_W-1:0]   scr_a_reg;
    logic signed [bcomp_pkg::OS_W-1:0]   scr_a_next;
    logic signed [bcomp_pkg::OS_W-1:0]   scr_b_reg;
    logic signed [bcomp_pkg::OS_W-1:0]   scr_b_next;
    logic signed [bcomp_pkg::PQ_W-1:0]   p_reg;
    logic signed [bcomp_pkg::PQ_W-1:0]   p_next;
    logic signed [bcomp_pkg::TEMP_W-1:0] comp_temp_reg;
    logic signed [bcomp_pkg::TEMP_W-1:0] comp_temp_next;
    logic                                have_reg;
    logic                                have_next;
    logic signed [bcomp_pkg::TEMP_W-1:0] res_temp_reg;
    logic signed [bcomp_pkg::TEMP_W-1:0] res_temp_next;
    logic [bcomp_pkg::PRES_W-1:0]        res_pres_reg;
    logic [bcomp_pkg::PRES_W-1:0]        res_pres_next;
    logic                                res_pv_reg;
    logic                                res_pv_next;
    logic                                ov_reg;
    logic                                ov_next;
    logic signed [bcomp_pkg::TEMP_W-1:0] o_temp_reg;
    logic signed [bcomp_pkg::TEMP_W-1:0] o_temp_next;
    logic [bcomp_pkg::PRES_W-1:0]        o_pres_reg;
    logic [bcomp_pkg::PRES_W-1:0]        o_pres_next;
    logic                                o_pv_reg;
    logic                                o_pv_next;

    bcomp_pkg::mul_req_t                 mreq;
    bcomp_pkg::mul_rsp_t                 mrsp;

    logic signed [bcomp_pkg::DT_W-1:0]   dt_in;
    logic signed [bcomp_pkg::TW_W-1:0]   d_val;
    logic signed [bcomp_pkg::TW_W-1:0]   e_val;
    logic signed [bcomp_pkg::OS_W-1:0]   fsq;
    logic signed [bcomp_pkg::PX_W-1:0]   px;
    logic signed [bcomp_pkg::TEMP_W-1:0] temp_sat;
    logic [bcomp_pkg::PRES_W-1:0]        pres_sat;
    logic                                out_free;

    bcomp_smul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign dt_in = $signed({1'b0, din.raw_sample})
                 - $signed({1'b0, cal.c5, {bcomp_pkg::SH_C5{1'b0}}});
    assign d_val = temp_reg - bcomp_pkg::TW_W'(bcomp_pkg::TEMP_REF);
    assign e_val = temp_reg - bcomp_pkg::TW_W'(bcomp_pkg::TEMP_LOW);
    assign fsq   = bcomp_pkg::OS_W'(mrsp.prod);
    assign px    = bcomp_pkg::PX_W'(mrsp.prod >>> bcomp_pkg::SH_P1)
                 - bcomp_pkg::PX_W'(off_reg);

    always_comb
    begin
        if (temp_reg < bcomp_pkg::TEMP_MIN)
        begin
            temp_sat = bcomp_pkg::TEMP_W'(bcomp_pkg::TEMP_MIN);
        end
        else if (temp_reg > bcomp_pkg::TEMP_MAX)
        begin
            temp_sat = bcomp_pkg::TEMP_W'(bcomp_pkg::TEMP_MAX);
        end
        else
        begin
            temp_sat = bcomp_pkg::TEMP_W'(temp_reg);
        end

        if (p_reg < 0)
        begin
            pres_sat = '0;
        end
        else if (p_reg > bcomp_pkg::PRES_MAX)
        begin
            pres_sat = bcomp_pkg::PRES_W'(bcomp_pkg::PRES_MAX);
        end
        else
        begin
            pres_sat = bcomp_pkg::PRES_W'(p_reg);
        end
    end

    assign out_free = !ov_reg || dout.ready;

    always_comb
    begin
        state_next     = state_reg;
        dt_next        = dt_reg;
        temp_next      = temp_reg;
        off_next       = off_reg;
        sens_next      = sens_reg;
        scr_a_next     = scr_a_reg;
        scr_b_next     = scr_b_reg;
        p_next         = p_reg;
        comp_temp_next = comp_temp_reg;
        have_next      = have_reg;
        res_temp_next  = res_temp_reg;
        res_pres_next  = res_pres_reg;
        res_pv_next    = res_pv_reg;
        mreq.start     = 1'b0;
        mreq.a         = bcomp_pkg::MA_W'(dt_reg);
        mreq.b         = bcomp_pkg::MB_W'(dt_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    dt_next = dt_in;
                    if (!din.action)
                    begin
                        mreq.start = 1'b1;
                        mreq.a     = bcomp_pkg::MA_W'(dt_in);
                        mreq.b     = bcomp_pkg::MB_W'(cal.c6);
                        state_next = S_M_TEMP;
                    end
                    else if (have_reg)
                    begin
                        mreq.start = 1'b1;
                        mreq.a     = sens_reg;
                        mreq.b     = bcomp_pkg::MB_W'(din.raw_sample);
                        state_next = S_M_PRES;
                    end
                    else
                    begin
                        res_temp_next = comp_temp_reg;
                        res_pres_next = '0;
                        res_pv_next   = 1'b0;
                        state_next    = S_OUT;
                    end
                end
            end
            S_M_TEMP:
            begin
                if (mrsp.done)
                begin
                    temp_next  = bcomp_pkg::TW_W'(bcomp_pkg::TEMP_REF)
                               + bcomp_pkg::TW_W'(mrsp.prod >>> bcomp_pkg::SH_TEMP);
                    mreq.start = 1'b1;
                    mreq.b     = bcomp_pkg::MB_W'(cal.c4);
                    state_next = S_M_OFF;
                end
            end
            S_M_OFF:
            begin
                if (mrsp.done)
                begin
                    off_next   = $signed(bcomp_pkg::OS_W'({cal.c2, {bcomp_pkg::SH_C2{1'b0}}}))
                               + bcomp_pkg::OS_W'(mrsp.prod >>> bcomp_pkg::SH_OFF);
                    mreq.start = 1'b1;
                    mreq.b     = bcomp_pkg::MB_W'(cal.c3);
                    state_next = S_M_SENS;
                end
            end
            S_M_SENS:
            begin
                if (mrsp.done)
                begin
                    sens_next = $signed(bcomp_pkg::OS_W'({cal.c1, {bcomp_pkg::SH_C1{1'b0}}}))
                              + bcomp_pkg::OS_W'(mrsp.prod >>> bcomp_pkg::SH_SENS);
                    if (temp_reg < bcomp_pkg::TEMP_REF)
                    begin
                        mreq.start = 1'b1;
                        mreq.a     = bcomp_pkg::MA_W'(d_val);
                        mreq.b     = bcomp_pkg::MB_W'(d_val);
                        state_next = S_M_F;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_M_F:
            begin
                if (mrsp.done)
                begin
                    scr_a_next = fsq + (fsq <<< 2);
                    state_next = S_F_APPLY;
                end
            end
            S_F_APPLY:
            begin
                off_next   = off_reg - (scr_a_reg >>> bcomp_pkg::SH_OFF2);
                sens_next  = sens_reg - (scr_a_reg >>> bcomp_pkg::SH_SENS2);
                mreq.start = 1'b1;
                if (temp_reg < bcomp_pkg::TEMP_LOW)
                begin
                    mreq.a     = bcomp_pkg::MA_W'(e_val);
                    mreq.b     = bcomp_pkg::MB_W'(e_val);
                    state_next = S_M_F2;
                end
                else
                begin
                    state_next = S_M_T2;
                end
            end
            S_M_F2:
            begin
                if (mrsp.done)
                begin
                    scr_a_next = (fsq <<< 3) - fsq;
                    scr_b_next = (fsq <<< 3) + (fsq <<< 1) + fsq;
                    state_next = S_F2_APPLY;
                end
            end
            S_F2_APPLY:
            begin
                off_next   = off_reg - scr_a_reg;
                sens_next  = sens_reg - (scr_b_reg >>> bcomp_pkg::SH_SENS3);
                mreq.start = 1'b1;
                state_next = S_M_T2;
            end
            S_M_T2:
            begin
                // The squared-dT term comes last, since the other terms use the
                // temperature before it is applied.
                if (mrsp.done)
                begin
                    temp_next  = temp_reg - bcomp_pkg::TW_W'(mrsp.prod >>> bcomp_pkg::SH_T2);
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                comp_temp_next = temp_sat;
                have_next      = 1'b1;
                res_temp_next  = temp_sat;
                res_pres_next  = '0;
                res_pv_next    = 1'b0;
                state_next     = S_OUT;
            end
            S_M_PRES:
            begin
                if (mrsp.done)
                begin
                    p_next     = bcomp_pkg::PQ_W'(px >>> bcomp_pkg::SH_P2);
                    state_next = S_P_CALC;
                end
            end
            S_P_CALC:
            begin
                res_temp_next = comp_temp_reg;
                res_pres_next = pres_sat;
                res_pv_next   = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next     = ov_reg;
        o_temp_next = o_temp_reg;
        o_pres_next = o_pres_reg;
        o_pv_next   = o_pv_reg;
        if (state_reg == S_OUT && out_free)
        begin
            ov_next     = 1'b1;
            o_temp_next = res_temp_reg;
            o_pres_next = res_pres_reg;
            o_pv_next   = res_pv_reg;
        end
        else if (dout.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_reg      <= 1'b0;
            comp_temp_reg <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_reg      <= have_next;
            comp_temp_reg <= comp_temp_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        temp_reg     <= temp_next;
        off_reg      <= off_next;
        sens_reg     <= sens_next;
        scr_a_reg    <= scr_a_next;
        scr_b_reg    <= scr_b_next;
        p_reg        <= p_next;
        res_temp_reg <= res_temp_next;
        res_pres_reg <= res_pres_next;
        res_pv_reg   <= res_pv_next;
        o_temp_reg   <= o_temp_next;
        o_pres_reg   <= o_pres_next;
        o_pv_reg     <= o_pv_next;
    end

    assign din.ready              = (state_reg == S_IDLE);
    assign dout.valid             = ov_reg;
    assign dout.temperature_centi = o_temp_reg;
    assign dout.pressure_pa       = o_pres_reg;
    assign dout.pressure_valid    = o_pv_reg;

endmodule

// ----- src/baro_temp_pressure_compensation_unit.sv -----
// Barometric sensor compensation with second-order temperature correction.
// The six calibration words C1..C6 are written through the APB port at byte
// addresses 0x00..0x14 and read back there; write them while the block is idle.
// Input transfers on din carry action (0 temperature, 1 pressure) and a 24-bit
// raw conversion. Every input transfer yields exactly one result transfer on
// dout: temperature in 0.01 C, pressure in Pa and a pressure-valid flag.
// A temperature transfer keeps TEMP, OFF and SENS for later pressure transfers.
// All products run through one shared radix-16 serial multiplier. A temperature
// item multiplies for TEMP, OFF and SENS, and for the second-order corrections
// when they apply; a pressure item multiplies once, or not at all before any
// temperature item. One item is in flight at a time; din ready rises as the
// result is registered, so the next item is not accepted before then.
// A finished result waits in the output register while dout is stalled; the
// next item is accepted and computed meanwhile and holds at the end until the
// register frees up.
// Reset clears the calibration words, the kept temperature and the have-
// temperature flag; a pressure transfer before any temperature returns zeros.
module baro_temp_pressure_compensation_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcomp_pkg::ADDR_W-1:0]   paddr,
    input  logic [bcomp_pkg::DATA_W-1:0]   pwdata,
    output logic [bcomp_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    bcomp_in_if.sink                       din,
    bcomp_out_if.source                    dout
);

    bcomp_pkg::cal_t cal;

    bcomp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    bcomp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cal   (cal),
        .din   (din),
        .dout  (dout)
    );

`ifndef ASSERT_OFF
    // One item at a time: a transfer in is never followed directly by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> !din.ready)
        else $error("input accepted while an item is in flight");

    // Temperature leaves the block saturated.
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.temperature_centi >= bcomp_pkg::TEMP_MIN
                     && dout.temperature_centi <= bcomp_pkg::TEMP_MAX))
        else $error("temperature outside its saturation range");

    // A result without a valid pressure carries no pressure.
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.pressure_valid |-> dout.pressure_pa == '0)
        else $error("pressure present without pressure_valid");
`endif

endmodule
